@@ design/asc7seg_pkg.sv @@
// ----------------------------------------------------------------------------
// asc7seg_pkg
// Shared constants, glyph table and types for the ASCII to seven-segment
// encoder.
// ----------------------------------------------------------------------------
package asc7seg_pkg;

    localparam int DIGIT_COUNT_DEFAULT = 6;

    localparam logic [7:0] SEG_UNKNOWN = 8'hFF;
    localparam logic [7:0] SEG_POINT   = 8'h80;
    localparam logic [7:0] CHAR_FIRST  = 8'h20;  // space
    localparam logic [7:0] CHAR_LAST   = 8'h7E;  // tilde
    localparam logic [7:0] CHAR_DOT    = 8'h2E;  // '.'

    localparam int GLYPH_COUNT = 95;

    // XABCDEFG order, indexed by code minus space
    localparam logic [7:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        8'h00, 8'hB0, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
        8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'h80, 8'hFF,
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'hFF, 8'hFF, 8'h65,
        8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
        8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
        8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
        8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
        8'h67, 8'hFF, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
        8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
    };

    // Decoded character handed from the glyph stage to the top level
    typedef struct packed {
        logic [7:0] segments;   // rewired byte
        logic       unknown;    // no representation
        logic       is_dot;
    } glyph_info_t;

endpackage

@@ design/asc7seg_glyph.sv @@
// ----------------------------------------------------------------------------
// asc7seg_glyph
// Glyph table lookup and rewiring to the normal or upside-down digit layout.
// ----------------------------------------------------------------------------
module asc7seg_glyph (
    input  logic                      [7:0] char_code,
    input  logic                            inverted_mode,
    input  logic                            point_in,
    output asc7seg_pkg::glyph_info_t        info
);

    logic       in_range;
    logic [6:0] rom_idx;
    logic [7:0] glyph;
    logic [7:0] wired;

    assign in_range = (char_code >= asc7seg_pkg::CHAR_FIRST) &&
                      (char_code <= asc7seg_pkg::CHAR_LAST);
    assign rom_idx  = 7'(char_code - asc7seg_pkg::CHAR_FIRST);
    assign glyph    = in_range ? asc7seg_pkg::GLYPH_ROM[rom_idx] : asc7seg_pkg::SEG_UNKNOWN;

    always_comb
    begin
        wired    = 8'h00;
        wired[7] = glyph[7];
        if (inverted_mode)
        begin
            // XGCBAFED, point may be carried in from a preceding dot
            wired[7] = glyph[7] | point_in;
            wired[3] = glyph[6];
            wired[4] = glyph[5];
            wired[5] = glyph[4];
            wired[0] = glyph[3];
            wired[1] = glyph[2];
            wired[2] = glyph[1];
            wired[6] = glyph[0];
        end
        else
        begin
            // XGFEDCBA
            wired[0] = glyph[6];
            wired[1] = glyph[5];
            wired[2] = glyph[4];
            wired[3] = glyph[3];
            wired[4] = glyph[2];
            wired[5] = glyph[1];
            wired[6] = glyph[0];
        end
    end

    assign info.segments = wired;
    assign info.unknown  = (glyph == asc7seg_pkg::SEG_UNKNOWN);
    assign info.is_dot   = (char_code == asc7seg_pkg::CHAR_DOT);

endmodule

@@ design/ascii_to_seven_segment_encoder_top.sv @@
// ----------------------------------------------------------------------------
// ascii_to_seven_segment_encoder_top
// Turns a character stream into digit write commands for a seven-segment
// display, with point merging and a digit limit.
// ----------------------------------------------------------------------------
// The result is registered: it is valid in the cycle after the input transfer.
// Throughput: one character per cycle; the only stage is the result register,
//   and ready stays high as long as that register is empty or being drained.
// Reset (rst_n low, asynchronous): no result pending, inverted_mode 0, and the
//   string state cleared as if a string had started at digit 0.
// ----------------------------------------------------------------------------
module ascii_to_seven_segment_encoder_top #(
    parameter int DIGIT_COUNT = asc7seg_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,

    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata,

    // character input
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       string_start,
    input  logic [2:0] first_digit,

    // digit write output
    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_valid,
    output logic [2:0] write_pos,
    output logic [7:0] segments,
    output logic       unknown_char,
    output logic       overflow,
    output logic [2:0] placed_count
);

    // position can reach DIGIT_COUNT itself, first_digit reaches 7
    localparam int POS_W = ($clog2(DIGIT_COUNT + 1) > 3) ? $clog2(DIGIT_COUNT + 1) : 3;

    logic             inverted_mode_reg;

    // running string state
    logic [POS_W-1:0] position_reg, position_next;
    logic [2:0]       origin_reg, origin_next;
    logic             dot_pending_reg, dot_pending_next;
    logic [7:0]       prev_seg_reg, prev_seg_next;
    logic             halted_reg, halted_next;

    // result register
    logic             out_valid_reg;
    logic             wv_reg, wv_next;
    logic [2:0]       wpos_reg, wpos_next;
    logic [7:0]       seg_reg, seg_next;
    logic             unk_reg, unk_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       placed_reg, placed_next;

    // state as seen by this character (string start overrides)
    logic [POS_W-1:0] pos_eff;
    logic [2:0]       origin_eff;
    logic             dot_eff;
    logic [7:0]       prev_eff;
    logic             halted_eff;

    logic                     in_xfer;
    asc7seg_pkg::glyph_info_t glyph;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    assign pos_eff    = string_start ? POS_W'(first_digit) : position_reg;
    assign origin_eff = string_start ? first_digit : origin_reg;
    assign dot_eff    = string_start ? 1'b0 : dot_pending_reg;
    assign prev_eff   = string_start ? 8'h00 : prev_seg_reg;
    assign halted_eff = string_start ? 1'b0 : halted_reg;

    asc7seg_glyph u_glyph (
        .char_code     (char_code),
        .inverted_mode (inverted_mode_reg),
        .point_in      (dot_eff),
        .info          (glyph)
    );

    always_comb
    begin
        position_next    = pos_eff;
        origin_next      = origin_eff;
        dot_pending_next = dot_eff;
        prev_seg_next    = prev_eff;
        halted_next      = halted_eff;

        wv_next   = 1'b0;
        wpos_next = 3'd0;
        seg_next  = 8'h00;
        unk_next  = 1'b0;
        ovf_next  = 1'b0;

        if (halted_eff)
        begin
            // string already dropped
            ovf_next = 1'b1;
        end
        else
        begin
            unk_next         = glyph.unknown;
            dot_pending_next = glyph.is_dot;
            if (glyph.is_dot)
            begin
                // normal mode: light the point of the last digit, if any
                if (!inverted_mode_reg && (pos_eff != POS_W'(origin_eff)))
                begin
                    prev_seg_next = prev_eff | asc7seg_pkg::SEG_POINT;
                    wv_next       = 1'b1;
                    wpos_next     = 3'(pos_eff - POS_W'(1));
                    seg_next      = prev_eff | asc7seg_pkg::SEG_POINT;
                end
            end
            else if (pos_eff >= POS_W'(DIGIT_COUNT))
            begin
                halted_next = 1'b1;
                ovf_next    = 1'b1;
            end
            else
            begin
                wv_next       = 1'b1;
                wpos_next     = 3'(pos_eff);
                seg_next      = glyph.segments;
                prev_seg_next = glyph.segments;
                position_next = pos_eff + POS_W'(1);
            end
        end

        placed_next = 3'(position_next - POS_W'(origin_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            inverted_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            origin_reg      <= 3'd0;
            dot_pending_reg <= 1'b0;
            prev_seg_reg    <= 8'h00;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                position_reg    <= position_next;
                origin_reg      <= origin_next;
                dot_pending_reg <= dot_pending_next;
                prev_seg_reg    <= prev_seg_next;
                halted_reg      <= halted_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg   <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            wv_reg     <= wv_next;
            wpos_reg   <= wpos_next;
            seg_reg    <= seg_next;
            unk_reg    <= unk_next;
            ovf_reg    <= ovf_next;
            placed_reg <= placed_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = wv_reg;
    assign write_pos    = wpos_reg;
    assign segments     = seg_reg;
    assign unknown_char = unk_reg;
    assign overflow     = ovf_reg;
    assign placed_count = placed_reg;

endmodule

@@ design/asc7seg_checker.sv @@
// ----------------------------------------------------------------------------
// asc7seg_checker
// Port-level checks for the ASCII to seven-segment encoder, bound to the top.
// ----------------------------------------------------------------------------
module asc7seg_checker #(
    parameter int DIGIT_COUNT = asc7seg_pkg::DIGIT_COUNT_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       string_start,
    input logic       out_valid,
    input logic       out_ready,
    input logic       write_valid,
    input logic [2:0] write_pos,
    input logic [7:0] segments,
    input logic       overflow,
    input logic [2:0] placed_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_valid) &&
        $stable(write_pos) && $stable(segments) && $stable(placed_count))
        else $error("stalled result changed");

    // an accepted character always yields a result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted character gave no result");

    // first character of a string places at most its own digit
    a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && string_start |=>
        placed_count == {2'b00, write_valid})
        else $error("placed count wrong on first character");

    // a result without a write carries zero payload and overflow never writes
    a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!write_valid || overflow) |->
        !write_valid && write_pos == 3'd0 && segments == 8'h00)
        else $error("bad payload on non-write result");

    // writes stay within the display
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> int'(write_pos) < DIGIT_COUNT)
        else $error("write past digit limit");

endmodule

bind ascii_to_seven_segment_encoder_top asc7seg_checker #(
    .DIGIT_COUNT(DIGIT_COUNT)
) u_asc7seg_checker (.*);

@@ dv/ascii_to_seven_segment_encoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// ascii_to_seven_segment_encoder_top_tb
// Self-checking bench for the ASCII to seven-segment encoder. A scoreboard
// keeps its own copy of the string state and the wiring mode, predicts one
// digit write per character transfer and checks every output transfer in
// order. Stimulus is a short directed string set followed by random strings,
// with random idling on both sides, one long output stall and mode changes
// between phases.
// ----------------------------------------------------------------------------
module ascii_to_seven_segment_encoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIGITS     = 6;
    localparam int PHASE_ITEMS    = 90;
    localparam int NUM_PHASES     = 5;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT    = 2000;   // cycles with no transfer at all
    localparam int IDLE_PCT       = 33;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] SEG_ALL  = 8'hFF;
    localparam logic [7:0] SEG_DP   = 8'h80;

    // Glyphs for space..tilde, XABCDEFG order; 0xFF marks "no glyph"
    localparam logic [7:0] GLYPHS [0:94] = '{
        8'h00, 8'hB0, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
        8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'h80, 8'hFF,
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
        8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'hFF, 8'hFF, 8'h65,
        8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
        8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
        8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
        8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
        8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
        8'h67, 8'hFF, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
        8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
    };

    // One digit write as seen on the output port
    typedef struct packed {
        logic       wr_valid;
        logic [2:0] wr_pos;
        logic [7:0] seg;
        logic       unknown;
        logic       ovf;
        logic [2:0] placed;
    } digit_write_t;

    // ------------------------------------------------------------------------
    // Scoreboard: string state, wiring mode and the queue of pending writes
    // ------------------------------------------------------------------------
    class digit_write_board;
        bit           inverted;
        logic [2:0]   next_pos;
        logic [2:0]   origin;
        bit           dot_waiting;
        bit           halted;
        logic [7:0]   last_seg;
        digit_write_t expected_writes[$];
        int           errors;

        // Power-on string state: as if a string had started at digit 0
        function void clear();
            inverted    = 1'b0;
            next_pos    = '0;
            origin      = '0;
            dot_waiting = 1'b0;
            halted      = 1'b0;
            last_seg    = '0;
            errors      = 0;
            expected_writes.delete();
        endfunction

        function void set_mode(input bit m);
            inverted = m;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Map XABCDEFG to the digit wiring; upside-down also takes a carried point
        function logic [7:0] rewire(input logic [7:0] g, input bit point_in);
            if (inverted)
                return {g[7] | point_in, g[0], g[4], g[5], g[6], g[1], g[2], g[3]};
            return {g[7], g[0], g[1], g[2], g[3], g[4], g[5], g[6]};
        endfunction

        // Predict the write caused by one character transfer
        function void note_char(input logic [7:0] ch, input bit start,
                                input logic [2:0] spos);
            digit_write_t w;
            logic [7:0]   g;
            logic [7:0]   data;
            bit           is_dot;
            w = '0;
            if (start) begin
                next_pos    = spos;
                origin      = spos;
                dot_waiting = 1'b0;
                last_seg    = '0;
                halted      = 1'b0;
            end
            if (halted) begin
                w.ovf = 1'b1;
            end
            else begin
                g = (ch >= CH_SPACE && ch <= CH_TILDE) ? GLYPHS[7'(ch - CH_SPACE)] : SEG_ALL;
                is_dot      = (ch == CH_DOT);
                w.unknown   = (g == SEG_ALL);
                data        = rewire(g, dot_waiting);
                dot_waiting = is_dot;
                if (is_dot) begin
                    // normal wiring: point goes on the previous digit, if any
                    if (!inverted && next_pos != origin) begin
                        last_seg   = last_seg | SEG_DP;
                        w.wr_valid = 1'b1;
                        w.wr_pos   = next_pos - 3'd1;
                        w.seg      = last_seg;
                    end
                end
                else if (int'(next_pos) >= NUM_DIGITS) begin
                    halted = 1'b1;
                    w.ovf  = 1'b1;
                end
                else begin
                    w.wr_valid = 1'b1;
                    w.wr_pos   = next_pos;
                    w.seg      = data;
                    last_seg   = data;
                    next_pos   = next_pos + 3'd1;
                end
            end
            w.placed = next_pos - origin;
            expected_writes.push_back(w);
        endfunction

        function void compare_field(input string field, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            end
        endfunction

        function void check_write(input digit_write_t got);
            digit_write_t want;
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t: digit write expected none got %h", $time, got);
            end
            else begin
                want = expected_writes.pop_front();
                compare_field("write_valid",  8'(want.wr_valid), 8'(got.wr_valid));
                compare_field("write_pos",    8'(want.wr_pos),   8'(got.wr_pos));
                compare_field("segments",     want.seg,          got.seg);
                compare_field("unknown_char", 8'(want.unknown),  8'(got.unknown));
                compare_field("overflow",     8'(want.ovf),      8'(got.ovf));
                compare_field("placed_count", 8'(want.placed),   8'(got.placed));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic       cfg_wdata    = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] char_code    = '0;
    logic       string_start = 1'b0;
    logic [2:0] first_digit  = '0;
    logic       out_ready    = 1'b0;

    logic       in_ready;
    logic       out_valid;
    logic       write_valid;
    logic [2:0] write_pos;
    logic [7:0] segments;
    logic       unknown_char;
    logic       overflow;
    logic [2:0] placed_count;

    // Flags from the sender to the receiver; always updated with NBAs so the
    // receiver sees them at the next edge regardless of process order.
    logic quiet       = 1'b0;   // no idling on either side
    logic rx_hold_req = 1'b0;   // ask the receiver for one long stall

    digit_write_board board;

    int  idle_cycles   = 0;
    int  rx_hold_left  = 0;
    bit  rx_hold_done  = 1'b0;

    // 100 MHz
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ascii_to_seven_segment_encoder_top #(
        .DIGIT_COUNT (NUM_DIGITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .string_start (string_start),
        .first_digit  (first_digit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_valid  (write_valid),
        .write_pos    (write_pos),
        .segments     (segments),
        .unknown_char (unknown_char),
        .overflow     (overflow),
        .placed_count (placed_count)
    );

    // ------------------------------------------------------------------------
    // Output side: check each transfer, then decide ready for the next edge.
    // The long stall is counted here, in the receiver's own process, while
    // the sender keeps offering characters so the result register fills and
    // in_ready drops.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_write({write_valid, write_pos, segments,
                               unknown_char, overflow, placed_count});
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one character and hold it until the transfer. A random number of
    // idle cycles comes first unless the quiet stretch is on. in_valid is not
    // dropped between back-to-back characters.
    task automatic send_char(input logic [7:0] ch, input logic st,
                             input logic [2:0] sp);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        char_code    <= ch;
        string_start <= st;
        first_digit  <= sp;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_char(ch, st, sp);
    endtask

    // Stop offering and wait for every predicted write to come out, then let
    // the single result stage settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Mode register write; only called with the block idle
    task automatic write_mode(input logic m);
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_mode(m);
    endtask

    // Mostly digits and letters, a fair share of points, some odd codes
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return CH_DOT;
        if (r < 55)
            return 8'($urandom_range(8'h30, 8'h39));
        if (r < 68)
            return 8'($urandom_range(8'h41, 8'h5A));
        if (r < 80)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 92)
            return 8'($urandom_range(CH_SPACE, CH_TILDE));
        return 8'($urandom_range(0, 255));
    endfunction

    // Directed strings: field extremes, unknown codes, point handling in both
    // wirings, the digit limit and the halted string.
    task automatic run_directed();
        // normal wiring; first string is implied by reset (origin 0)
        send_char(CH_DOT, 1'b0, 3'd0);   // leading point: nothing placed
        send_char(CH_SPACE, 1'b0, 3'd0);
        send_char(CH_TILDE, 1'b0, 3'd0);
        send_char(CH_DOT, 1'b0, 3'd0);   // point on the tilde digit
        send_char(8'h00, 1'b0, 3'd0);    // code zero is just an unknown char
        send_char(8'hFF, 1'b0, 3'd7);
        send_char(8'h7F, 1'b0, 3'd0);
        send_char(8'h1F, 1'b0, 3'd0);    // last digit
        send_char(CH_DOT, 1'b0, 3'd0);   // point still lands at the limit
        send_char("A", 1'b0, 3'd0);      // overflow
        send_char("B", 1'b0, 3'd0);      // string halted
        send_char("x", 1'b1, 3'd7);      // start past the limit
        send_char(CH_DOT, 1'b1, 3'd6);   // leading point at the limit
        send_char("8", 1'b0, 3'd0);
        send_char("8", 1'b1, 3'd5);
        send_char(CH_DOT, 1'b0, 3'd0);
        send_char("q", 1'b0, 3'd0);
        send_char("4", 1'b1, 3'd2);
        send_char(CH_DOT, 1'b0, 3'd0);
        drain();
        // upside-down wiring, same string continues across the mode change
        write_mode(1'b1);
        send_char("5", 1'b0, 3'd0);
        send_char(CH_DOT, 1'b0, 3'd0);
        send_char(CH_DOT, 1'b0, 3'd0);   // two points: still one carried
        send_char("a", 1'b0, 3'd0);
        send_char(CH_DOT, 1'b0, 3'd0);
        send_char("1", 1'b1, 3'd0);      // new string drops the carried point
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int         n;
        int         len;
        logic [2:0] spos;
        bit         paused;
        board = new();
        board.clear();
        paused = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        run_directed();

        // Random phases; the mode toggles at each boundary, phase 2 has no
        // idling at all, phase 1 carries the long receiver stall.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_mode(p % 2 == 0);
            quiet <= (p == 2);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (p == 1 && n >= 40)
                    rx_hold_req <= 1'b1;
                if (p == 3 && n >= 45 && !paused) begin
                    // sender waits until every pending write has come out
                    paused = 1'b1;
                    drain();
                end
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any byte, any start flag, any first digit
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)));
                    n++;
                end
                else begin
                    len  = $urandom_range(1, 9);
                    spos = ($urandom_range(0, 7) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
                    for (int k = 0; k < len; k++) begin
                        // first_digit of later characters is ignored; keep it random
                        send_char(pick_char(), k == 0,
                                  (k == 0) ? spos : 3'($urandom_range(0, 7)));
                        n++;
                    end
                end
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/asc7seg_pkg.sv
design/asc7seg_glyph.sv
design/ascii_to_seven_segment_encoder_top.sv
design/asc7seg_checker.sv
dv/ascii_to_seven_segment_encoder_top_tb.sv
